// ===== rtl/s5rp_pkg.sv =====
// Shared types and constants for the SOCKS5 client reply parser.
`default_nettype none
package s5rp_pkg;

    // Receive buffer limit for one phase, in bytes
    localparam int RX_BUF_BYTES = 512;

    // Protocol constants
    localparam logic [7:0] SOCKS_VER5      = 8'h05;
    localparam logic [7:0] METHOD_NONE     = 8'h00;
    localparam logic [7:0] METHOD_USERPASS = 8'h02;
    localparam logic [7:0] STATUS_OK       = 8'h00;
    localparam logic [7:0] ATYP_IPV4       = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN     = 8'h03;
    localparam logic [7:0] ATYP_IPV6       = 8'h04;

    // Expected lengths of the receive phases
    localparam logic [8:0] LEN_METHOD  = 9'd2;
    localparam logic [8:0] LEN_AUTH    = 9'd2;
    localparam logic [8:0] LEN_HEAD    = 9'd4;
    localparam logic [8:0] LEN_IPV4    = 9'd6;
    localparam logic [8:0] LEN_IPV6    = 9'd18;
    localparam logic [8:0] LEN_DLEN    = 9'd1;
    localparam logic [8:0] LEN_PORT    = 9'd2;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_CLOSE = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_CONNECT = 3'd1,
        ACT_AUTH    = 3'd2,
        ACT_ESTAB   = 3'd3,
        ACT_FAILED  = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        RSN_NONE      = 3'd0,
        RSN_BAD_VER   = 3'd1,
        RSN_NO_METHOD = 3'd2,
        RSN_AUTH_REJ  = 3'd3,
        RSN_REFUSED   = 3'd4,
        RSN_BAD_ATYP  = 3'd5,
        RSN_CLOSED    = 3'd6,
        RSN_OVERSIZE  = 3'd7
    } t_reason;

    // One result transaction
    typedef struct packed {
        t_action    action;
        t_reason    fail_reason;
        logic [7:0] reply_code;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/socks5_client_reply_parser_unit.sv =====
// SOCKS5 client reply parser: top level.
// Usage:
//   Input channel (i_in_valid / o_in_stall, payload i_op, i_rx_byte): one
//   transaction per event: start after the method request went out, one
//   received proxy byte, or peer closed / receive error.
//   Output channel (o_out_valid / i_out_stall, payload o_action,
//   o_fail_reason, o_reply_code): exactly one result per input transaction,
//   in order, telling the host to send the connect or auth request, that the
//   tunnel is up, why the handshake failed, or that no action is due.
//   Configuration: i_cfg_we / i_cfg_wdata write auth_enabled; write only
//   while no transaction is in flight.
// Timing: the result is registered and appears in the cycle after acceptance;
//   one transaction per cycle while the output is not stalled, set by the
//   single phase-check stage feeding the result register.
// Reset: synchronous active-low i_rst_n returns to idle, clears the stored
//   bytes and counters, clears auth_enabled and empties the result register.
// Stall: while a result is held and i_out_stall is high, o_in_stall is high
//   and no new transaction is taken; the held result stays unchanged.
`default_nettype none
module socks5_client_reply_parser_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [2:0]      o_action,
    output logic [2:0]      o_fail_reason,
    output logic [7:0]      o_reply_code
);

    logic              in_accept;
    s5rp_pkg::t_result core_result;
    s5rp_pkg::t_result out_result;

    assign in_accept = i_in_valid && !o_in_stall;

    // Phase tracking and checks
    s5rp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (in_accept),
        .i_op        (i_op),
        .i_rx_byte   (i_rx_byte),
        .o_result    (core_result)
    );

    // Result register
    s5rp_oreg u_oreg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (in_accept),
        .i_result     (core_result),
        .i_out_stall  (i_out_stall),
        .o_full_stall (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_result     (out_result)
    );

    assign o_action      = out_result.action;
    assign o_fail_reason = out_result.fail_reason;
    assign o_reply_code  = out_result.reply_code;

endmodule
`default_nettype wire

// ===== rtl/s5rp_core.sv =====
// Handshake phase tracking and reply checks, one accepted input transaction per cycle.
`default_nettype none
module s5rp_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata,
    input  wire logic              i_accept,
    input  wire logic [1:0]        i_op,
    input  wire logic [7:0]        i_rx_byte,
    output s5rp_pkg::t_result      o_result
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_METHOD = 3'd1,
        PH_AUTH   = 3'd2,
        PH_HEAD   = 3'd3,
        PH_ADDR   = 3'd4,
        PH_DOMAIN = 3'd5,
        PH_ESTAB  = 3'd6,
        PH_FAILED = 3'd7
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [8:0] r_cnt, n_cnt;
    logic [8:0] r_exp, n_exp;
    logic [7:0] r_first, n_first;
    logic [7:0] r_second, n_second;
    logic       r_auth_en;

    s5rp_pkg::t_action n_action;
    s5rp_pkg::t_reason n_reason;

    logic       active;
    logic [8:0] cnt_inc;
    logic [8:0] dom_want;

    assign active   = (r_phase >= PH_METHOD) && (r_phase <= PH_DOMAIN);
    assign cnt_inc  = r_cnt + 9'd1;
    assign dom_want = {1'b0, i_rx_byte} + s5rp_pkg::LEN_PORT;

    // Compute next phase, stored bytes and the result of this transaction
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_exp    = r_exp;
        n_first  = r_first;
        n_second = r_second;
        n_action = s5rp_pkg::ACT_NONE;
        n_reason = s5rp_pkg::RSN_NONE;

        unique case (i_op)
            s5rp_pkg::OP_START: begin
                n_first  = '0;
                n_second = '0;
                n_phase  = PH_METHOD;
                n_cnt    = '0;
                n_exp    = s5rp_pkg::LEN_METHOD;
            end
            s5rp_pkg::OP_BYTE: begin
                if (active) begin
                    // capture the two header bytes of the short phases
                    if (r_phase <= PH_HEAD) begin
                        if (r_cnt == 9'd0) begin
                            n_first = i_rx_byte;
                        end else if (r_cnt == 9'd1) begin
                            n_second = i_rx_byte;
                        end
                    end
                    n_cnt = cnt_inc;
                    // phase complete: check it and pick the next one
                    if (cnt_inc >= r_exp) begin
                        n_cnt = '0;
                        unique case (r_phase)
                            PH_METHOD: begin
                                if (n_first != s5rp_pkg::SOCKS_VER5) begin
                                    n_action = s5rp_pkg::ACT_FAILED;
                                    n_reason = s5rp_pkg::RSN_BAD_VER;
                                end else if (n_second == s5rp_pkg::METHOD_NONE) begin
                                    n_second = '0;
                                    n_phase  = PH_HEAD;
                                    n_exp    = s5rp_pkg::LEN_HEAD;
                                    n_action = s5rp_pkg::ACT_CONNECT;
                                end else if (n_second == s5rp_pkg::METHOD_USERPASS
                                             && r_auth_en) begin
                                    n_phase  = PH_AUTH;
                                    n_exp    = s5rp_pkg::LEN_AUTH;
                                    n_action = s5rp_pkg::ACT_AUTH;
                                end else begin
                                    n_action = s5rp_pkg::ACT_FAILED;
                                    n_reason = s5rp_pkg::RSN_NO_METHOD;
                                end
                            end
                            PH_AUTH: begin
                                if (n_second != s5rp_pkg::STATUS_OK) begin
                                    n_action = s5rp_pkg::ACT_FAILED;
                                    n_reason = s5rp_pkg::RSN_AUTH_REJ;
                                end else begin
                                    n_second = '0;
                                    n_phase  = PH_HEAD;
                                    n_exp    = s5rp_pkg::LEN_HEAD;
                                    n_action = s5rp_pkg::ACT_CONNECT;
                                end
                            end
                            PH_HEAD: begin
                                if (n_first != s5rp_pkg::SOCKS_VER5) begin
                                    n_action = s5rp_pkg::ACT_FAILED;
                                    n_reason = s5rp_pkg::RSN_BAD_VER;
                                end else if (n_second != 8'h00) begin
                                    n_action = s5rp_pkg::ACT_FAILED;
                                    n_reason = s5rp_pkg::RSN_REFUSED;
                                end else if (i_rx_byte == s5rp_pkg::ATYP_IPV4) begin
                                    n_phase = PH_ADDR;
                                    n_exp   = s5rp_pkg::LEN_IPV4;
                                end else if (i_rx_byte == s5rp_pkg::ATYP_IPV6) begin
                                    n_phase = PH_ADDR;
                                    n_exp   = s5rp_pkg::LEN_IPV6;
                                end else if (i_rx_byte == s5rp_pkg::ATYP_DOMAIN) begin
                                    n_phase = PH_DOMAIN;
                                    n_exp   = s5rp_pkg::LEN_DLEN;
                                end else begin
                                    n_action = s5rp_pkg::ACT_FAILED;
                                    n_reason = s5rp_pkg::RSN_BAD_ATYP;
                                end
                            end
                            PH_DOMAIN: begin
                                if (r_exp == s5rp_pkg::LEN_DLEN) begin
                                    if (int'(dom_want) > s5rp_pkg::RX_BUF_BYTES) begin
                                        n_action = s5rp_pkg::ACT_FAILED;
                                        n_reason = s5rp_pkg::RSN_OVERSIZE;
                                    end else begin
                                        n_exp = dom_want;
                                    end
                                end else begin
                                    n_phase  = PH_ESTAB;
                                    n_exp    = '0;
                                    n_action = s5rp_pkg::ACT_ESTAB;
                                end
                            end
                            default: begin
                                // address and port bytes received: tunnel is up
                                n_phase  = PH_ESTAB;
                                n_exp    = '0;
                                n_action = s5rp_pkg::ACT_ESTAB;
                            end
                        endcase
                    end
                end
            end
            s5rp_pkg::OP_CLOSE: begin
                if (active) begin
                    n_action = s5rp_pkg::ACT_FAILED;
                    n_reason = s5rp_pkg::RSN_CLOSED;
                end
            end
            default: begin
                n_action = s5rp_pkg::ACT_NONE;
            end
        endcase

        // enter the failed phase; drop the method or auth status byte before the reply head
        if (n_action == s5rp_pkg::ACT_FAILED) begin
            if (r_phase < PH_HEAD) begin
                n_second = '0;
            end
            n_phase = PH_FAILED;
            n_cnt   = '0;
            n_exp   = '0;
        end
    end

    // Result of the current transaction, from the updated state
    always_comb begin
        o_result.action      = n_action;
        o_result.fail_reason = n_reason;
        o_result.reply_code  = (n_phase >= PH_HEAD) ? n_second : 8'h00;
    end

    // Hold state; advance on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cnt     <= '0;
            r_exp     <= '0;
            r_first   <= '0;
            r_second  <= '0;
            r_auth_en <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_auth_en <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_phase  <= n_phase;
                r_cnt    <= n_cnt;
                r_exp    <= n_exp;
                r_first  <= n_first;
                r_second <= n_second;
            end
        end
    end

    // A receive phase never holds a full count
    a_cnt_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        active |-> (r_cnt < r_exp))
        else $error("byte count reached expected length inside a phase");

    // A failure result lands in the failed phase
    a_fail_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (o_result.action == s5rp_pkg::ACT_FAILED)) |=>
        (r_phase == PH_FAILED))
        else $error("failure reported without entering failed phase");

    // A reason is given exactly when the handshake fails
    a_reason_only_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> ((o_result.fail_reason != s5rp_pkg::RSN_NONE) ==
                      (o_result.action == s5rp_pkg::ACT_FAILED)))
        else $error("fail reason and action disagree");

    // Established phase is reached only with an established result
    a_estab_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (r_phase != PH_ESTAB) && (n_phase == PH_ESTAB)) |->
        (o_result.action == s5rp_pkg::ACT_ESTAB))
        else $error("entered established phase silently");

endmodule
`default_nettype wire

// ===== rtl/s5rp_oreg.sv =====
// Result register that decouples the output channel from the input channel.
`default_nettype none
module s5rp_oreg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire s5rp_pkg::t_result i_result,
    input  wire logic              i_out_stall,
    output logic                   o_full_stall,
    output logic                   o_out_valid,
    output s5rp_pkg::t_result      o_result
);

    logic                r_valid;
    s5rp_pkg::t_result   r_result;
    logic                out_take;

    assign out_take     = r_valid && !i_out_stall;
    // Refuse a new transaction only while the held result is stalled
    assign o_full_stall = r_valid && i_out_stall;
    assign o_out_valid  = r_valid;
    assign o_result     = r_result;

    // Hold valid until the result is taken; reload on a new transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (out_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    // Never overwrite a result that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !(r_valid && i_out_stall))
        else $error("result overwritten while stalled");

    // A loaded transaction is presented in the next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_valid && (r_result == $past(i_result))))
        else $error("loaded result not presented");

endmodule
`default_nettype wire
